// ===== rtl/core/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for point rotation about a center
// Payload structs, request codes, controller states, CORDIC angle table and
// fixed-point helpers used by the controller and the datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Field widths (Q15.8 coordinates, binary angles).
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;

  // CORDIC iteration count bounds.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Fixed-point scaling.
  localparam int SCALE_SHIFT = 16;
  localparam int GAIN_FRAC   = 20;

  // Internal widths.
  localparam int RW  = COORD_W + 20;       // CORDIC x/y registers
  localparam int ZW  = 34;                 // CORDIC angle residual
  localparam int MW  = RW - SCALE_SHIFT;   // rounded magnitude / quotient
  localparam int DW  = MW + GAIN_FRAC + 1; // divider dividend
  localparam int PW  = 22;                 // squared-gain divisor
  localparam int SW  = COORD_W + 6;        // coordinate sums before saturation

  localparam logic signed [SW-1:0] COORD_MAX = SW'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [SW-1:0] COORD_MIN = -COORD_MAX - SW'(1);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ROTATE = 2'd1,
    REQ_MOVE_X = 2'd2,
    REQ_MOVE_Y = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_CENTER_X = 1'b0,
    CFG_CENTER_Y = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_type_e                   req_type;
    logic                        point_sel;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;
    logic signed [ANGLE_W-1:0]   angle_step;
  } prc_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [ANGLE_W-1:0]   point_angle_out;
  } prc_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_VEC_GO,
    S_VEC_RUN,
    S_VEC_END,
    S_ROT_GO,
    S_ROT_RUN,
    S_DIV_GO,
    S_DIV_RUN,
    S_WRITE,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic vec_start;
    logic vec_end;
    logic rot_start;
    logic div_start;
    logic write_back;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rotate;
    logic cordic_done;
    logic div_done;
  } dp_sts_t;

  // atan(2^-i) with 2^32 as a full turn.
  function automatic logic [31:0] atan_entry(logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335086;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41721;
      5'd15: a = 32'd20860;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2607;
      5'd19: a = 32'd1303;
      5'd20: a = 32'd651;
      5'd21: a = 32'd325;
      5'd22: a = 32'd162;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Squared CORDIC gain in Q20, evaluated at elaboration.
  function automatic logic [PW-1:0] gain_sq(int steps);
    logic [31:0] p;
    p = 32'd1 << GAIN_FRAC;
    for (int i = 0; i < steps; i++) begin
      p = p + (p >> (2 * i));
    end
    return p[PW-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [SW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/prc_cordic.sv =====
// ----------------------------------------------------------------------------
// prc_cordic: iterative CORDIC unit
// One micro-rotation per cycle; vectoring mode steers by the sign of y,
// rotation mode by the sign of the angle residual.
// ----------------------------------------------------------------------------
module prc_cordic #(
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              vec_mode_i,
  input  logic signed [prc_pkg::RW-1:0]     x_i,
  input  logic signed [prc_pkg::RW-1:0]     y_i,
  input  logic signed [prc_pkg::ZW-1:0]     z_i,
  output logic                              done_o,
  output logic signed [prc_pkg::RW-1:0]     x_o,
  output logic signed [prc_pkg::RW-1:0]     y_o,
  output logic signed [prc_pkg::ZW-1:0]     z_o
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic [CNT_W-1:0]                 cnt_q;
  logic                             run_q, done_q, vec_q;
  logic signed [prc_pkg::RW-1:0]    x_q, y_q, x_d, y_d, xs, ys;
  logic signed [prc_pkg::ZW-1:0]    z_q, z_d, at;
  logic                             ccw;
  logic                             last;

  assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    at  = $signed({2'b00, prc_pkg::atan_entry(5'(cnt_q))});
    ccw = vec_q ? !y_q[prc_pkg::RW-1] : z_q[prc_pkg::ZW-1];
    x_d = ccw ? x_q + ys : x_q - ys;
    y_d = ccw ? y_q - xs : y_q + xs;
    z_d = ccw ? z_q + at : z_q - at;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        vec_q <= vec_mode_i;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== rtl/core/prc_div.sv =====
// ----------------------------------------------------------------------------
// prc_div: divide by a constant through reciprocal multiplication
// Four pipelined steps: split product by the reciprocal, quotient estimate,
// back-multiply by the divisor, and one correction step.
// ----------------------------------------------------------------------------
module prc_div #(
  parameter logic [prc_pkg::PW-1:0] DIVISOR = prc_pkg::gain_sq(prc_pkg::CORDIC_STEPS_DEF)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [prc_pkg::DW-1:0]      dividend_i,
  output logic                        done_o,
  output logic [prc_pkg::MW-1:0]      quot_o
);

  localparam int DW   = prc_pkg::DW;
  localparam int MW   = prc_pkg::MW;
  localparam int PW   = prc_pkg::PW;
  localparam int LO_W = DW / 2;
  localparam int HI_W = DW - LO_W;
  localparam int BW   = MW + PW;

  // floor(2^DW / DIVISOR); the divisor is above 2^21, so this fits MW bits
  // and the estimate is at most one below the true quotient.
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << DW) / 64'(DIVISOR));

  logic                   s0_q, s1_q, s2_q, s3_q, done_q;
  logic [DW-1:0]          num_q;
  logic [LO_W+MW-1:0]     plo_q;
  logic [HI_W+MW-1:0]     phi_q;
  logic [DW+MW-1:0]       prod;
  logic [MW-1:0]          qe_q, quot_q;
  logic [BW-1:0]          back_q, rem;
  logic                   ge;

  always_comb begin
    prod = {phi_q, {LO_W{1'b0}}} + (DW+MW)'(plo_q);
    rem  = BW'(num_q) - back_q;
    ge   = (rem >= BW'(DIVISOR));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= 1'b0;
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      s3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s0_q   <= start_i;
      s1_q   <= s0_q;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      done_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (s0_q) begin
      plo_q <= (LO_W+MW)'(num_q[LO_W-1:0]) * (LO_W+MW)'(RECIP);
      phi_q <= (HI_W+MW)'(num_q[DW-1:LO_W]) * (HI_W+MW)'(RECIP);
    end
    if (s1_q) begin
      qe_q <= prod[DW +: MW];
    end
    if (s2_q) begin
      back_q <= BW'(qe_q) * BW'(DIVISOR);
    end
    if (s3_q) begin
      // add one when the remainder still holds a whole divisor
      quot_q <= qe_q + MW'(ge);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/prc_datapath.sv =====
// ----------------------------------------------------------------------------
// prc_datapath: endpoint state, CORDIC and descaling datapath
// Holds both endpoints, their angles and stale marks, the center registers,
// and runs vectoring, rotation and gain division on controller commands.
// ----------------------------------------------------------------------------
module prc_datapath #(
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prc_pkg::dp_cmd_t                  cmd_i,
  input  prc_pkg::prc_req_t                 req_i,
  input  logic                              cfg_we_i,
  input  prc_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [prc_pkg::COORD_W-1:0]       cfg_wdata_i,
  output prc_pkg::dp_sts_t                  sts_o,
  output prc_pkg::prc_res_t                 res_o
);

  localparam int CW = prc_pkg::COORD_W;
  localparam int AW = prc_pkg::ANGLE_W;
  localparam int RW = prc_pkg::RW;
  localparam int ZW = prc_pkg::ZW;
  localparam int MW = prc_pkg::MW;
  localparam int DW = prc_pkg::DW;
  localparam int SW = prc_pkg::SW;
  localparam logic [prc_pkg::PW-1:0] GAIN_P = prc_pkg::gain_sq(CORDIC_STEPS);

  logic signed [CW-1:0]   center_x_q, center_y_q;
  logic signed [CW-1:0]   end_x_q [2];
  logic signed [CW-1:0]   end_y_q [2];
  logic [AW-1:0]          end_angle_q [2];
  logic [1:0]             stale_q;

  prc_pkg::prc_req_t      req_q;
  prc_pkg::prc_res_t      res_q;
  logic signed [RW-1:0]   mag_q;
  logic                   zero_q;
  logic                   sgn_x_q, sgn_y_q;

  logic                   sel;
  logic signed [CW-1:0]   cur_x, cur_y;
  logic signed [CW:0]     dx, dy;
  logic signed [RW-1:0]   u0, v0, rx0;
  logic signed [ZW-1:0]   z_vec0, z_rot0;
  logic [31:0]            th, th_adj, z_round;
  logic                   flip;
  logic [AW-1:0]          ang_meas, ang_cur, ang_new;
  logic signed [SW-1:0]   mv_sum;

  logic                   cor_start, cor_done;
  logic signed [RW-1:0]   cor_x_in, cor_y_in, cor_x, cor_y;
  logic signed [ZW-1:0]   cor_z_in, cor_z;

  logic [RW-1:0]          abs_x, abs_y;
  logic [RW:0]            rnd_x, rnd_y;
  logic [DW-1:0]          dvd_x, dvd_y;
  logic                   div_done_x, div_done_y;
  logic [MW-1:0]          quot_x, quot_y;
  logic signed [SW-1:0]   q_x, q_y, wb_x, wb_y;

  assign sel   = req_q.point_sel;
  assign cur_x = end_x_q[sel];
  assign cur_y = end_y_q[sel];

  // Vectoring start: offset from center, y flipped to point up, left half folded by a half turn.
  always_comb begin
    dx = (CW+1)'(cur_x) - (CW+1)'(center_x_q);
    dy = (CW+1)'(cur_y) - (CW+1)'(center_y_q);
    if (dx < 0) begin
      u0     = RW'(-dx) <<< prc_pkg::SCALE_SHIFT;
      v0     = RW'(dy) <<< prc_pkg::SCALE_SHIFT;
      z_vec0 = ZW'(64'h8000_0000);
    end else begin
      u0     = RW'(dx) <<< prc_pkg::SCALE_SHIFT;
      v0     = -(RW'(dy) <<< prc_pkg::SCALE_SHIFT);
      z_vec0 = '0;
    end
  end

  // Angle after vectoring, rounded half up.
  always_comb begin
    z_round  = cor_z[31:0] + (32'd1 << (31 - AW));
    ang_meas = zero_q ? '0 : z_round[31 -: AW];
    ang_cur  = stale_q[sel] ? ang_meas : end_angle_q[sel];
    ang_new  = ang_cur + req_q.angle_step;
  end

  // Rotation start: fold the second and third quadrants by a half turn.
  always_comb begin
    th     = 32'(end_angle_q[sel]) << (32 - AW);
    flip   = th[31] ^ th[30];
    th_adj = flip ? (th ^ 32'h8000_0000) : th;
    rx0    = flip ? -mag_q : mag_q;
    z_rot0 = ZW'($signed(th_adj));
  end

  assign cor_start = cmd_i.vec_start | cmd_i.rot_start;
  assign cor_x_in  = cmd_i.vec_start ? u0 : rx0;
  assign cor_y_in  = cmd_i.vec_start ? v0 : '0;
  assign cor_z_in  = cmd_i.vec_start ? z_vec0 : z_rot0;

  prc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cor_start),
    .vec_mode_i (cmd_i.vec_start),
    .x_i        (cor_x_in),
    .y_i        (cor_y_in),
    .z_i        (cor_z_in),
    .done_o     (cor_done),
    .x_o        (cor_x),
    .y_o        (cor_y),
    .z_o        (cor_z)
  );

  // Round magnitudes by the scale, then divide by the squared gain.
  always_comb begin
    abs_x = cor_x[RW-1] ? RW'(-cor_x) : RW'(cor_x);
    abs_y = cor_y[RW-1] ? RW'(-cor_y) : RW'(cor_y);
    rnd_x = {1'b0, abs_x} + (RW+1)'(1 << (prc_pkg::SCALE_SHIFT - 1));
    rnd_y = {1'b0, abs_y} + (RW+1)'(1 << (prc_pkg::SCALE_SHIFT - 1));
    dvd_x = (DW'(rnd_x[prc_pkg::SCALE_SHIFT +: MW]) << prc_pkg::GAIN_FRAC)
            + DW'(GAIN_P >> 1);
    dvd_y = (DW'(rnd_y[prc_pkg::SCALE_SHIFT +: MW]) << prc_pkg::GAIN_FRAC)
            + DW'(GAIN_P >> 1);
  end

  prc_div #(
    .DIVISOR (GAIN_P)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_x),
    .done_o     (div_done_x),
    .quot_o     (quot_x)
  );

  prc_div #(
    .DIVISOR (GAIN_P)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_y),
    .done_o     (div_done_y),
    .quot_o     (quot_y)
  );

  always_comb begin
    q_x  = sgn_x_q ? -SW'(quot_x) : SW'(quot_x);
    q_y  = sgn_y_q ? -SW'(quot_y) : SW'(quot_y);
    wb_x = SW'(center_x_q) + q_x;
    wb_y = SW'(center_y_q) - q_y;
  end

  always_comb begin
    unique case (req_q.req_type)
      prc_pkg::REQ_MOVE_X: mv_sum = SW'(cur_x) + SW'(req_q.coord_x);
      prc_pkg::REQ_MOVE_Y: mv_sum = SW'(cur_y) + SW'(req_q.coord_y);
      default:             mv_sum = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      end_x_q[0]     <= '0;
      end_x_q[1]     <= '0;
      end_y_q[0]     <= '0;
      end_y_q[1]     <= '0;
      end_angle_q[0] <= '0;
      end_angle_q[1] <= '0;
      stale_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          prc_pkg::CFG_CENTER_X: center_x_q <= cfg_wdata_i;
          prc_pkg::CFG_CENTER_Y: center_y_q <= cfg_wdata_i;
          default: ;
        endcase
        stale_q <= 2'b11;
      end
      if (cmd_i.update) begin
        unique case (req_q.req_type)
          prc_pkg::REQ_LOAD: begin
            end_x_q[sel] <= req_q.coord_x;
            end_y_q[sel] <= req_q.coord_y;
          end
          prc_pkg::REQ_MOVE_X: end_x_q[sel] <= prc_pkg::sat_coord(mv_sum);
          prc_pkg::REQ_MOVE_Y: end_y_q[sel] <= prc_pkg::sat_coord(mv_sum);
          default: ;
        endcase
        stale_q <= 2'b11;
      end
      if (cmd_i.vec_end) begin
        end_angle_q[sel] <= (req_q.req_type == prc_pkg::REQ_ROTATE) ? ang_new : ang_meas;
        stale_q[sel]     <= 1'b0;
      end
      if (cmd_i.write_back) begin
        end_x_q[sel] <= prc_pkg::sat_coord(wb_x);
        end_y_q[sel] <= prc_pkg::sat_coord(wb_y);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.vec_start) begin
      zero_q <= (dx == '0) && (dy == '0);
    end
    if (cmd_i.vec_end) begin
      mag_q <= cor_x;
    end
    if (cmd_i.div_start) begin
      sgn_x_q <= cor_x[RW-1];
      sgn_y_q <= cor_y[RW-1];
    end
    if (cmd_i.emit) begin
      res_q.point_x         <= cur_x;
      res_q.point_y         <= cur_y;
      res_q.point_angle_out <= end_angle_q[sel];
    end
  end

  assign sts_o.is_rotate   = (req_q.req_type == prc_pkg::REQ_ROTATE);
  assign sts_o.cordic_done = cor_done;
  assign sts_o.div_done    = div_done_x & div_done_y;
  assign res_o             = res_q;

endmodule

// ===== rtl/core/prc_ctrl.sv =====
// ----------------------------------------------------------------------------
// prc_ctrl: request sequencer
// Steps loads and moves through update and vectoring, rotations through
// vectoring, rotation, division and write-back; raises the result strobe.
// ----------------------------------------------------------------------------
module prc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  prc_pkg::dp_sts_t      sts_i,
  output prc_pkg::dp_cmd_t      cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  prc_pkg::ctrl_state_e state_q, state_d;
  logic                 done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prc_pkg::S_IDLE:    if (start_i) state_d = prc_pkg::S_UPDATE;
      prc_pkg::S_UPDATE:  state_d = prc_pkg::S_VEC_GO;
      prc_pkg::S_VEC_GO:  state_d = prc_pkg::S_VEC_RUN;
      prc_pkg::S_VEC_RUN: if (sts_i.cordic_done) state_d = prc_pkg::S_VEC_END;
      prc_pkg::S_VEC_END: state_d = sts_i.is_rotate ? prc_pkg::S_ROT_GO : prc_pkg::S_FIN;
      prc_pkg::S_ROT_GO:  state_d = prc_pkg::S_ROT_RUN;
      prc_pkg::S_ROT_RUN: if (sts_i.cordic_done) state_d = prc_pkg::S_DIV_GO;
      prc_pkg::S_DIV_GO:  state_d = prc_pkg::S_DIV_RUN;
      prc_pkg::S_DIV_RUN: if (sts_i.div_done) state_d = prc_pkg::S_WRITE;
      prc_pkg::S_WRITE:   state_d = prc_pkg::S_FIN;
      prc_pkg::S_FIN:     state_d = prc_pkg::S_IDLE;
      default:            state_d = prc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == prc_pkg::S_IDLE) && start_i;
    cmd_o.update     = (state_q == prc_pkg::S_UPDATE) && !sts_i.is_rotate;
    cmd_o.vec_start  = (state_q == prc_pkg::S_VEC_GO);
    cmd_o.vec_end    = (state_q == prc_pkg::S_VEC_END);
    cmd_o.rot_start  = (state_q == prc_pkg::S_ROT_GO);
    cmd_o.div_start  = (state_q == prc_pkg::S_DIV_GO);
    cmd_o.write_back = (state_q == prc_pkg::S_WRITE);
    cmd_o.emit       = (state_q == prc_pkg::S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prc_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == prc_pkg::S_FIN);
    end
  end

  assign busy_o = (state_q != prc_pkg::S_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(state_q) == prc_pkg::S_FIN)
    else $error("result strobe outside of request completion");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.cordic_done |-> (state_q == prc_pkg::S_VEC_RUN || state_q == prc_pkg::S_ROT_RUN))
    else $error("CORDIC finished while not awaited");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == prc_pkg::S_DIV_RUN)
    else $error("divider finished while not awaited");
`endif

endmodule

// ===== rtl/core/point_rotation_about_center.sv =====
// ----------------------------------------------------------------------------
// point_rotation_about_center: two endpoints rotated about a center
// Loads, moves and rotates two screen-space endpoints (y down) and keeps
// their polar angles about a configurable center, using an iterative CORDIC.
// ----------------------------------------------------------------------------
//
//  channel   ports                              direction  handshake
//  -------   ---------------------------------  ---------  ----------------------
//  request   start, busy, req_i                 in         start && !busy
//  result    done_o, res_o                      out        done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i   in         cfg_we_i, no wait
//
//  Load and move requests pass from accept through update and vectoring to
//  the result strobe; rotate requests then also run a CORDIC rotation, the
//  reciprocal divide and write-back before the strobe. The CORDIC unit does
//  one micro-rotation per cycle.
//  One request is in flight at a time; busy stays high until the strobe.
//  Reset clears the center and both endpoints; no clearing pass is needed.
//  The receiver cannot stall: done_o is high for a single cycle per result.
//
//  A center write, load or move marks both angles stale. Each request measures
//  its endpoint; a rotate steps the stored angle, or the measured one if stale.
//
module point_rotation_about_center #(
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Request channel
  input  logic                              start,
  output logic                              busy,
  input  prc_pkg::prc_req_t                 req_i,

  // Result channel
  output logic                              done_o,
  output prc_pkg::prc_res_t                 res_o,

  // Configuration write port
  input  logic                              cfg_we_i,
  input  prc_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [prc_pkg::COORD_W-1:0]       cfg_wdata_i
);

  prc_pkg::dp_cmd_t  cmd;
  prc_pkg::dp_sts_t  sts;

  // Sequence each request.
  prc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Hold endpoint state and run the arithmetic.
  prc_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule
